// ===== hw/rtl/cit_pkg.sv =====
// shared types, constants and sample tables of the complex index interpolator
package cit_pkg;

  localparam int unsigned ROM_POINTS  = 24;
  localparam int unsigned WAVE_W      = 16;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned SEG_W       = $clog2(ROM_POINTS);
  localparam int unsigned QUEUE_DEPTH = 4;

  // sample wavelengths in 0.1 nm, strictly ascending
  localparam logic [WAVE_W-1:0] ROM_WAVE [ROM_POINTS] = '{
    16'd2066, 16'd2254, 16'd2480, 16'd2755, 16'd3100, 16'd3542, 16'd4133, 16'd4275,
    16'd4428, 16'd4592, 16'd4769, 16'd4959, 16'd5166, 16'd5391, 16'd5636, 16'd5904,
    16'd6199, 16'd6526, 16'd6888, 16'd7293, 16'd7749, 16'd8266, 16'd8856, 16'd9534
  };

  // real index, unsigned q4.12
  localparam logic [VAL_W-1:0] ROM_RE [ROM_POINTS] = '{
    16'd5923,  16'd5923,  16'd7651,  16'd10043, 16'd10260, 16'd10363, 16'd11608, 16'd12317,
    16'd12841, 16'd13074, 16'd13230, 16'd13414, 16'd13767, 16'd14651, 16'd15557, 16'd15606,
    16'd15413, 16'd15172, 16'd14942, 16'd14750, 16'd14574, 16'd14410, 16'd14352, 16'd14336
  };

  // extinction coefficient, unsigned q4.12
  localparam logic [VAL_W-1:0] ROM_IM [ROM_POINTS] = '{
    16'd6963, 16'd7864, 16'd8847, 16'd8110, 16'd6717, 16'd6717, 16'd7496, 16'd7455,
    16'd7004, 16'd6636, 16'd6390, 16'd6308, 16'd6390, 16'd6390, 16'd5366, 16'd4342,
    16'd3604, 16'd3097, 16'd2732, 16'd2425, 16'd2208, 16'd2044, 16'd1720, 16'd1638
  };

  typedef enum logic [1:0] {
    REGION_INTERP = 2'd0,
    REGION_BELOW  = 2'd1,
    REGION_ABOVE  = 2'd2
  } region_e;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [WAVE_W-1:0] wave;
    logic [SEG_W-1:0]  seg;
    region_e           region;
  } cit_item_t;

endpackage

// ===== hw/rtl/cit_front.sv =====
// front end: compares the wavelength with the sample points and picks the segment
module cit_front #(
  parameter int unsigned POINTS_USED = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [cit_pkg::WAVE_W-1:0] in_wave_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cit_pkg::cit_item_t        out_item_o
);
  import cit_pkg::*;

  localparam int unsigned LAST = POINTS_USED - 1;

  logic                   adv;
  logic                   v1_q, v2_q;
  logic [WAVE_W-1:0]      wave_q;
  logic [POINTS_USED-1:0] ge_d, ge_q;
  logic                   above_d, above_q;
  cit_item_t              item_d, item_q;

  assign adv        = !v2_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    for (int i = 0; i < POINTS_USED; i++) begin
      ge_d[i] = in_wave_i >= ROM_WAVE[i];
    end
    above_d = in_wave_i > ROM_WAVE[LAST];
  end

  // thermometer code to segment index, top segment ends at the last point
  always_comb begin
    logic [SEG_W-1:0] seg;
    seg = '0;
    for (int i = 0; i < LAST; i++) begin
      if (ge_q[i] && ((i == LAST - 1) || !ge_q[i+1])) begin
        seg = seg | SEG_W'(i);
      end
    end
    item_d.wave = wave_q;
    item_d.seg  = seg;
    if (!ge_q[0]) begin
      item_d.region = REGION_BELOW;
    end else if (above_q) begin
      item_d.region = REGION_ABOVE;
    end else begin
      item_d.region = REGION_INTERP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wave_q  <= in_wave_i;
      ge_q    <= ge_d;
      above_q <= above_d;
      item_q  <= item_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item_q;

endmodule

// ===== hw/rtl/cit_queue.sv =====
// short fifo of classified items between front and back
module cit_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cit_pkg::cit_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cit_pkg::cit_item_t out_item_o
);
  import cit_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cit_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = count_q != (PTR_W+1)'(QUEUE_DEPTH);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// ===== hw/rtl/cit_back.sv =====
// back end: sample lookup, weighting products and pipelined restoring divide
module cit_back #(
  parameter int unsigned POINTS_USED = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  cit_pkg::cit_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [cit_pkg::VAL_W-1:0] out_re_o,
  output logic [cit_pkg::VAL_W-1:0] out_im_o,
  output cit_pkg::region_e          out_region_o
);
  import cit_pkg::*;

  localparam int unsigned LAST      = POINTS_USED - 1;
  localparam int unsigned DIV_STEPS = VAL_W;
  localparam int unsigned PROD_W    = VAL_W + WAVE_W;

  logic adv;

  // lookup stage
  logic              v0_q;
  logic [VAL_W-1:0]  a_re_d, b_re_d, a_im_d, b_im_d, a_re_q, b_re_q, a_im_q, b_im_q;
  logic [WAVE_W-1:0] d1_d, d2_d, span_d, d1_q, d2_q, span0_q;
  region_e           reg0_q;

  // product stage
  logic              v1_q;
  logic [PROD_W-1:0] pa_re_q, pb_re_q, pa_im_q, pb_im_q;
  logic [WAVE_W-1:0] span1_q;
  region_e           reg1_q;

  // divider stages, index 0 holds the weighted sum
  logic              vd_q   [DIV_STEPS+1];
  logic [WAVE_W-1:0] rre_q  [DIV_STEPS+1];
  logic [VAL_W-1:0]  lre_q  [DIV_STEPS+1];
  logic [WAVE_W-1:0] rim_q  [DIV_STEPS+1];
  logic [VAL_W-1:0]  lim_q  [DIV_STEPS+1];
  region_e           regd_q [DIV_STEPS+1];
  logic [WAVE_W-1:0] spand_q [DIV_STEPS];

  logic [WAVE_W-1:0] rre_d [DIV_STEPS];
  logic [VAL_W-1:0]  lre_d [DIV_STEPS];
  logic [WAVE_W-1:0] rim_d [DIV_STEPS];
  logic [VAL_W-1:0]  lim_d [DIV_STEPS];
  logic [PROD_W-1:0] sum_re, sum_im;

  assign adv        = !vd_q[DIV_STEPS] || out_ready_i;
  assign in_ready_o = adv;

  // clamped items go through as a*1/1
  always_comb begin
    logic [SEG_W-1:0] s0, s1;
    s0     = in_item_i.seg;
    s1     = in_item_i.seg + SEG_W'(1);
    a_re_d = ROM_RE[s0];
    b_re_d = ROM_RE[s1];
    a_im_d = ROM_IM[s0];
    b_im_d = ROM_IM[s1];
    d1_d   = in_item_i.wave - ROM_WAVE[s0];
    d2_d   = ROM_WAVE[s1] - in_item_i.wave;
    span_d = ROM_WAVE[s1] - ROM_WAVE[s0];
    unique case (in_item_i.region)
      REGION_BELOW: begin
        a_re_d = ROM_RE[0];
        b_re_d = ROM_RE[0];
        a_im_d = ROM_IM[0];
        b_im_d = ROM_IM[0];
        d1_d   = '0;
        d2_d   = WAVE_W'(1);
        span_d = WAVE_W'(1);
      end
      REGION_ABOVE: begin
        a_re_d = ROM_RE[LAST];
        b_re_d = ROM_RE[LAST];
        a_im_d = ROM_IM[LAST];
        b_im_d = ROM_IM[LAST];
        d1_d   = '0;
        d2_d   = WAVE_W'(1);
        span_d = WAVE_W'(1);
      end
      default: begin
      end
    endcase
  end

  // sum stays below 2^VAL_W * span, so it fits the product width
  assign sum_re = pa_re_q + pb_re_q;
  assign sum_im = pa_im_q + pb_im_q;

  // one quotient bit per stage
  always_comb begin
    logic [WAVE_W:0] t_re, t_im, dv;
    logic            ge_re, ge_im;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv       = {1'b0, spand_q[k]};
      t_re     = {rre_q[k], lre_q[k][VAL_W-1]};
      t_im     = {rim_q[k], lim_q[k][VAL_W-1]};
      ge_re    = t_re >= dv;
      ge_im    = t_im >= dv;
      rre_d[k] = ge_re ? WAVE_W'(t_re - dv) : t_re[WAVE_W-1:0];
      rim_d[k] = ge_im ? WAVE_W'(t_im - dv) : t_im[WAVE_W-1:0];
      lre_d[k] = {lre_q[k][VAL_W-2:0], ge_re};
      lim_d[k] = {lim_q[k][VAL_W-2:0], ge_im};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v0_q    <= in_valid_i;
      v1_q    <= v0_q;
      vd_q[0] <= v1_q;
      for (int k = 0; k < DIV_STEPS; k++) begin
        vd_q[k+1] <= vd_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_re_q  <= a_re_d;
      b_re_q  <= b_re_d;
      a_im_q  <= a_im_d;
      b_im_q  <= b_im_d;
      d1_q    <= d1_d;
      d2_q    <= d2_d;
      span0_q <= span_d;
      reg0_q  <= in_item_i.region;

      pa_re_q <= a_re_q * d2_q;
      pb_re_q <= b_re_q * d1_q;
      pa_im_q <= a_im_q * d2_q;
      pb_im_q <= b_im_q * d1_q;
      span1_q <= span0_q;
      reg1_q  <= reg0_q;

      rre_q[0]   <= sum_re[PROD_W-1:VAL_W];
      lre_q[0]   <= sum_re[VAL_W-1:0];
      rim_q[0]   <= sum_im[PROD_W-1:VAL_W];
      lim_q[0]   <= sum_im[VAL_W-1:0];
      spand_q[0] <= span1_q;
      regd_q[0]  <= reg1_q;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rre_q[k+1]  <= rre_d[k];
        lre_q[k+1]  <= lre_d[k];
        rim_q[k+1]  <= rim_d[k];
        lim_q[k+1]  <= lim_d[k];
        regd_q[k+1] <= regd_q[k];
      end
      for (int k = 0; k < DIV_STEPS - 1; k++) begin
        spand_q[k+1] <= spand_q[k];
      end
    end
  end

  assign out_valid_o  = vd_q[DIV_STEPS];
  assign out_re_o     = lre_q[DIV_STEPS];
  assign out_im_o     = lim_q[DIV_STEPS];
  assign out_region_o = regd_q[DIV_STEPS];

  // remainders of the last stage are not needed
  logic unused_rem;
  assign unused_rem = ^{rre_q[DIV_STEPS], rim_q[DIV_STEPS]};

endmodule

// ===== hw/rtl/complex_index_table_interpolator.sv =====
// top level of the complex refractive index interpolator
//
// takes one wavelength item (0.1 nm units) and returns the complex refractive
// index as two unsigned q4.12 values plus a region code, by linear
// interpolation between the two sample points that bracket the wavelength;
// outside the sample range the end entry is returned and tuser says on which
// side. one item is accepted per cycle while the output is not stalled, and
// results come out in order: two front stages compare the wavelength against
// every sample point in use and pick the segment, a 4-entry queue decouples
// front from back, and the back does the sample lookup, the weighting products
// and a 16-stage restoring divider that retires one quotient bit per stage.
// TABLE_ENTRIES selects how many sample points are used and is held between 2
// and 24.
module complex_index_table_interpolator #(
  parameter int unsigned TABLE_ENTRIES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] wavelength
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] index_real, [31:16] index_imag
  output logic [1:0]  m_axis_tuser    // [1:0] region
);
  import cit_pkg::*;

  // points in use, held to what the sample rom provides
  localparam int unsigned POINTS_USED =
    (TABLE_ENTRIES < 2) ? 2 : ((TABLE_ENTRIES > ROM_POINTS) ? ROM_POINTS : TABLE_ENTRIES);
  localparam int unsigned LAST = POINTS_USED - 1;

  // front to queue
  logic      fq_valid, fq_ready;
  cit_item_t fq_item;
  // queue to back
  logic      qb_valid, qb_ready;
  cit_item_t qb_item;

  logic [VAL_W-1:0] res_re, res_im;
  region_e          res_region;

  cit_front #(
    .POINTS_USED (POINTS_USED)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_wave_i   (s_axis_tdata),
    .out_valid_o (fq_valid),
    .out_ready_i (fq_ready),
    .out_item_o  (fq_item)
  );

  cit_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_item_i   (fq_item),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_item_o  (qb_item)
  );

  cit_back #(
    .POINTS_USED (POINTS_USED)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (qb_valid),
    .in_ready_o   (qb_ready),
    .in_item_i    (qb_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_re_o     (res_re),
    .out_im_o     (res_im),
    .out_region_o (res_region)
  );

  assign m_axis_tdata = {res_im, res_re};
  assign m_axis_tuser = res_region;

  // clamped below: first sample must survive products and divider unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_region == REGION_BELOW) |->
      (res_re == ROM_RE[0] && res_im == ROM_IM[0]))
    else $error("below-range result differs from first sample");

  // clamped above: last sample in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_region == REGION_ABOVE) |->
      (res_re == ROM_RE[LAST] && res_im == ROM_IM[LAST]))
    else $error("above-range result differs from last sample");

  // interpolated real part stays within the sample range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_region == REGION_INTERP) |->
      (res_re >= 16'd5923 && res_re <= 16'd15606))
    else $error("interpolated real index out of sample range");

endmodule

// ===== bench/complex_index_table_interpolator_tb.sv =====
// self-checking bench of the complex index interpolator: directed corners, then random lookups
module complex_index_table_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cit_pkg::*;

  localparam int unsigned PTS = 24;
  localparam int unsigned RANDOM_PER_PHASE = 450;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  // sample points: wavelength in 0.1 nm, real part and extinction in q4.12
  localparam logic [15:0] WAVE_PTS [PTS] = '{
    16'd2066, 16'd2254, 16'd2480, 16'd2755, 16'd3100, 16'd3542, 16'd4133, 16'd4275,
    16'd4428, 16'd4592, 16'd4769, 16'd4959, 16'd5166, 16'd5391, 16'd5636, 16'd5904,
    16'd6199, 16'd6526, 16'd6888, 16'd7293, 16'd7749, 16'd8266, 16'd8856, 16'd9534
  };
  localparam logic [15:0] RE_PTS [PTS] = '{
    16'd5923, 16'd5923, 16'd7651, 16'd10043, 16'd10260, 16'd10363, 16'd11608, 16'd12317,
    16'd12841, 16'd13074, 16'd13230, 16'd13414, 16'd13767, 16'd14651, 16'd15557,
    16'd15606, 16'd15413, 16'd15172, 16'd14942, 16'd14750, 16'd14574, 16'd14410,
    16'd14352, 16'd14336
  };
  localparam logic [15:0] IM_PTS [PTS] = '{
    16'd6963, 16'd7864, 16'd8847, 16'd8110, 16'd6717, 16'd6717, 16'd7496, 16'd7455,
    16'd7004, 16'd6636, 16'd6390, 16'd6308, 16'd6390, 16'd6390, 16'd5366, 16'd4342,
    16'd3604, 16'd3097, 16'd2732, 16'd2425, 16'd2208, 16'd2044, 16'd1720, 16'd1638
  };

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic [1:0]  region;
  } index_result_t;

  // one directed lookup; pinned rows carry a hand-read answer, others use the predictor
  typedef struct packed {
    logic [15:0]   wave;
    logic          pinned;
    index_result_t want;
  } lookup_row_t;

  localparam int unsigned N_DIRECTED = 21;
  localparam lookup_row_t DIRECTED [N_DIRECTED] = '{
    '{16'd0,     1'b1, '{16'd5923,  16'd6963, REGION_BELOW}},
    '{16'd1,     1'b1, '{16'd5923,  16'd6963, REGION_BELOW}},
    '{16'd2065,  1'b1, '{16'd5923,  16'd6963, REGION_BELOW}},
    '{16'd2066,  1'b1, '{16'd5923,  16'd6963, REGION_INTERP}},
    '{16'd2067,  1'b0, '{16'd0,     16'd0,    REGION_INTERP}},
    '{16'd2160,  1'b0, '{16'd0,     16'd0,    REGION_INTERP}},
    '{16'd2254,  1'b1, '{16'd5923,  16'd7864, REGION_INTERP}},
    '{16'd3099,  1'b0, '{16'd0,     16'd0,    REGION_INTERP}},
    '{16'd4133,  1'b1, '{16'd11608, 16'd7496, REGION_INTERP}},
    '{16'd4134,  1'b0, '{16'd0,     16'd0,    REGION_INTERP}},
    '{16'h1555,  1'b0, '{16'd0,     16'd0,    REGION_INTERP}},
    '{16'd5904,  1'b1, '{16'd15606, 16'd4342, REGION_INTERP}},
    '{16'd7000,  1'b0, '{16'd0,     16'd0,    REGION_INTERP}},
    '{16'd8266,  1'b1, '{16'd14410, 16'd2044, REGION_INTERP}},
    '{16'd9533,  1'b0, '{16'd0,     16'd0,    REGION_INTERP}},
    '{16'd9534,  1'b1, '{16'd14336, 16'd1638, REGION_INTERP}},
    '{16'd9535,  1'b1, '{16'd14336, 16'd1638, REGION_ABOVE}},
    '{16'h2AAA,  1'b1, '{16'd14336, 16'd1638, REGION_ABOVE}},
    '{16'h5555,  1'b1, '{16'd14336, 16'd1638, REGION_ABOVE}},
    '{16'd32768, 1'b1, '{16'd14336, 16'd1638, REGION_ABOVE}},
    '{16'd65535, 1'b1, '{16'd14336, 16'd1638, REGION_ABOVE}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // travels beside s_axis_tdata so the acceptance edge sees the matching answer
  logic          row_pinned = 1'b0;
  index_result_t row_want = '0;

  int unsigned send_idle_pct = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  index_result_t index_q [$];

  always #6 clk_i = ~clk_i;

  complex_index_table_interpolator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clamp at the ends, else blend the bracketing pair weighted by distance, truncated
  function automatic index_result_t interp_index(input logic [15:0] w);
    index_result_t r;
    int unsigned d1;
    int unsigned d2;
    logic found;
    r.re = RE_PTS[0];
    r.im = IM_PTS[0];
    r.region = REGION_INTERP;
    found = 1'b0;
    if (w < WAVE_PTS[0]) begin
      r.region = REGION_BELOW;
    end else if (w > WAVE_PTS[PTS-1]) begin
      r.re = RE_PTS[PTS-1];
      r.im = IM_PTS[PTS-1];
      r.region = REGION_ABOVE;
    end else begin
      for (int k = 0; k + 1 < PTS; k++) begin
        if (!found && w >= WAVE_PTS[k] && w <= WAVE_PTS[k+1]) begin
          found = 1'b1;
          d1 = w - WAVE_PTS[k];
          d2 = WAVE_PTS[k+1] - w;
          r.re = 16'((RE_PTS[k] * d2 + RE_PTS[k+1] * d1) / (d1 + d2));
          r.im = 16'((IM_PTS[k] * d2 + IM_PTS[k+1] * d1) / (d1 + d2));
        end
      end
    end
    return r;
  endfunction

  // mostly in-table lookups, with sample points, edges, both clamp sides and raw noise
  function automatic logic [15:0] pick_wavelength();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 16'($urandom_range(WAVE_PTS[0], WAVE_PTS[PTS-1]));
    if (roll < 67) return WAVE_PTS[$urandom_range(0, PTS - 1)];
    if (roll < 75) return 16'(WAVE_PTS[$urandom_range(0, PTS - 1)] + $urandom_range(0, 2) - 1);
    if (roll < 83) return 16'($urandom_range(0, WAVE_PTS[0] - 1));
    if (roll < 91) return 16'($urandom_range(WAVE_PTS[PTS-1] + 1, 65535));
    return 16'($urandom);
  endfunction

  // hold the item on the bus until it is taken, with random idle cycles ahead of it
  task automatic send_wavelength(input logic [15:0] w, input logic pinned,
                                 input index_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    row_pinned    <= pinned;
    row_want      <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // wait out every outstanding lookup with the input side quiet
  task automatic drain_lookups();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (index_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // record accepted lookups, then check results in order
  always @(posedge clk_i) begin
    index_result_t got;
    index_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        index_q.push_back(row_pinned ? row_want : interp_index(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.re     = m_axis_tdata[15:0];
        got.im     = m_axis_tdata[31:16];
        got.region = m_axis_tuser;
        if (index_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result re=%0d im=%0d region=%0d",
                     got.re, got.im, got.region);
        end else begin
          want = index_q.pop_front();
          if (got.re !== want.re || got.im !== want.im || got.region !== want.region) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected re=%0d im=%0d region=%0d, got re=%0d im=%0d region=%0d",
                       want.re, want.im, want.region, got.re, got.im, got.region);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", index_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // phases: no idling, sender idle, receiver stalling, both a little
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 69; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 69; end
        default: begin send_idle_pct = 17; ready_stall_pct = 17; end
      endcase
      if (phase == 0) begin
        for (int r = 0; r < N_DIRECTED; r++)
          send_wavelength(DIRECTED[r].wave, DIRECTED[r].pinned, DIRECTED[r].want);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_wavelength(pick_wavelength(), 1'b0, '0);
      drain_lookups();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && index_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cit_pkg.sv
hw/rtl/cit_front.sv
hw/rtl/cit_queue.sv
hw/rtl/cit_back.sv
hw/rtl/complex_index_table_interpolator.sv
bench/complex_index_table_interpolator_tb.sv
